/* design/spectrum_band_bar_levels_defines.svh */
`ifndef SPECTRUM_BAND_BAR_LEVELS_DEFINES_SVH
`define SPECTRUM_BAND_BAR_LEVELS_DEFINES_SVH

// same-cycle implication under reset
`define SBBL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SBBL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sbbl_pkg.sv */
`default_nettype none

package sbbl_pkg;

    localparam int NUM_BANDS_DEF  = 32;
    localparam int NUM_LEVELS_DEF = 8;
    localparam int NUM_BINS_DEF   = 1024;

    localparam int TABLE_BANDS = 32;
    localparam int BIN_W       = 11;
    localparam int BAND_W      = 6;
    localparam int TOTAL_W     = 24;
    localparam int LEVEL_W     = 12;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 1'd1;

    localparam logic signed [LEVEL_W-1:0] MIN_LEVEL_RST = -12'sd1600;
    localparam logic signed [LEVEL_W-1:0] MAX_LEVEL_RST = -12'sd96;

    localparam logic [BIN_W-1:0] BIN_MAX = 11'h7FF;

    localparam logic [BIN_W-1:0] EDGE_TABLE [0:TABLE_BANDS] = '{
        11'd0,   11'd1,   11'd2,   11'd3,   11'd4,   11'd6,   11'd7,   11'd9,
        11'd10,  11'd13,  11'd16,  11'd19,  11'd24,  11'd29,  11'd35,  11'd43,
        11'd53,  11'd64,  11'd78,  11'd96,  11'd116, 11'd142, 11'd173, 11'd211,
        11'd257, 11'd313, 11'd381, 11'd465, 11'd566, 11'd690, 11'd840, 11'd980,
        11'd1023
    };

    typedef struct packed {
        logic take;
        logic load_mul;
        logic div_step;
        logic push;
    } sbbl_cmd_t;

    typedef struct packed {
        logic band_close;
        logic out_free;
    } sbbl_stat_t;

    function automatic logic [BIN_W-1:0] band_edge(input logic [BAND_W-1:0] idx);
        logic [BIN_W-1:0] e;
        e = '0;
        if (idx <= BAND_W'(TABLE_BANDS)) begin
            e = EDGE_TABLE[idx];
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* design/sbbl_ctrl.sv */
`default_nettype none

module sbbl_ctrl #(
    parameter int NUM_LEVELS = sbbl_pkg::NUM_LEVELS_DEF
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  sbbl_pkg::sbbl_stat_t   stat,
    output sbbl_pkg::sbbl_cmd_t    cmd
);

    localparam int QW     = $clog2(NUM_LEVELS + 1);
    localparam int STEP_W = (QW > 2) ? $clog2(QW) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_PUSH = 4'b1000
    } sbbl_state_t;

    sbbl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take = s_valid;
                if (s_valid && stat.band_close) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.load_mul = 1'b1;
                step_next    = STEP_W'(QW - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_PUSH;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

/* design/sbbl_datapath.sv */
`default_nettype none

module sbbl_datapath #(
    parameter int NUM_BANDS  = sbbl_pkg::NUM_BANDS_DEF,
    parameter int NUM_LEVELS = sbbl_pkg::NUM_LEVELS_DEF,
    parameter int NUM_BINS   = sbbl_pkg::NUM_BINS_DEF
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     cfg_valid,
    input  wire  [sbbl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire  [sbbl_pkg::LEVEL_W-1:0]            cfg_data,
    input  wire  signed [sbbl_pkg::LEVEL_W-1:0]     s_power_level,
    input  wire                                     s_frame_start,
    input  sbbl_pkg::sbbl_cmd_t                     cmd,
    output sbbl_pkg::sbbl_stat_t                    stat,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic [4:0]                              m_column,
    output logic [2:0]                              m_height,
    output logic                                    m_last_column
);

    localparam int BIN_W   = sbbl_pkg::BIN_W;
    localparam int BAND_W  = sbbl_pkg::BAND_W;
    localparam int TOTAL_W = sbbl_pkg::TOTAL_W;
    localparam int LEVEL_W = sbbl_pkg::LEVEL_W;
    localparam int NB      = (NUM_BANDS < sbbl_pkg::TABLE_BANDS) ?
                             NUM_BANDS : sbbl_pkg::TABLE_BANDS;
    localparam int QW      = $clog2(NUM_LEVELS + 1);
    localparam int DEN_W   = BIN_W + LEVEL_W;
    localparam int WIDE_W  = TOTAL_W + QW;

    // config
    logic signed [LEVEL_W-1:0] min_level_reg, max_level_reg;

    // frame state
    logic [BIN_W-1:0]   bin_counter_reg;
    logic [BAND_W-1:0]  band_number_reg;
    logic [TOTAL_W-1:0] band_total_reg;

    // closed band and divider
    logic [BIN_W-1:0]  width_reg;
    logic [4:0]        column_reg;
    logic              last_reg;
    logic              ok_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] dsh_reg;
    logic [QW-1:0]     q_reg;

    logic              m_valid_reg;
    logic [4:0]        m_column_reg;
    logic [2:0]        m_height_reg;
    logic              m_last_reg;

    logic [BIN_W-1:0]          b;
    logic [BAND_W-1:0]         bn;
    logic [TOTAL_W-1:0]        tot;
    logic [BIN_W-1:0]          lo, hi;
    logic                      in_band;
    logic                      range_ok;
    logic signed [LEVEL_W:0]   diff;
    logic [LEVEL_W-1:0]        range_val;
    logic signed [LEVEL_W-1:0] clamped;
    logic signed [LEVEL_W:0]   offset;
    logic [LEVEL_W-1:0]        add_val;
    logic [TOTAL_W:0]          sum_wide;
    logic [TOTAL_W-1:0]        sum_sat;
    logic [DEN_W-1:0]          den;
    logic [QW-1:0]             q_capped;

    always_comb begin
        b   = s_frame_start ? '0 : bin_counter_reg;
        bn  = s_frame_start ? '0 : band_number_reg;
        tot = s_frame_start ? '0 : band_total_reg;
        lo  = sbbl_pkg::band_edge(bn);
        hi  = sbbl_pkg::band_edge(bn + BAND_W'(1));
        in_band = (bn < BAND_W'(NB)) && ({1'b0, b} < (BIN_W + 1)'(NUM_BINS))
                  && (b >= lo) && (b < hi);

        diff      = {max_level_reg[LEVEL_W-1], max_level_reg}
                  - {min_level_reg[LEVEL_W-1], min_level_reg};
        range_ok  = max_level_reg > min_level_reg;
        range_val = range_ok ? diff[LEVEL_W-1:0] : '0;

        if (s_power_level < min_level_reg) begin
            clamped = min_level_reg;
        end else if (s_power_level > max_level_reg) begin
            clamped = max_level_reg;
        end else begin
            clamped = s_power_level;
        end
        offset  = {clamped[LEVEL_W-1], clamped} - {min_level_reg[LEVEL_W-1], min_level_reg};
        add_val = range_ok ? offset[LEVEL_W-1:0] : '0;

        sum_wide = {1'b0, tot} + (TOTAL_W + 1)'(add_val);
        sum_sat  = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];

        stat.band_close = in_band && (({1'b0, b} + (BIN_W + 1)'(1)) == {1'b0, hi});
        stat.out_free   = !m_valid_reg || m_ready;

        den = DEN_W'(width_reg) * DEN_W'(range_val);

        q_capped = (q_reg > QW'(NUM_LEVELS - 1)) ? QW'(NUM_LEVELS - 1) : q_reg;
    end

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg <= sbbl_pkg::MIN_LEVEL_RST;
            max_level_reg <= sbbl_pkg::MAX_LEVEL_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbbl_pkg::REG_MIN_LEVEL: min_level_reg <= cfg_data;
                sbbl_pkg::REG_MAX_LEVEL: max_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // bin and band tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_counter_reg <= '0;
            band_number_reg <= '0;
            band_total_reg  <= '0;
        end else if (cmd.take) begin
            bin_counter_reg <= (b < sbbl_pkg::BIN_MAX) ? b + BIN_W'(1) : b;
            band_number_reg <= stat.band_close ? bn + BAND_W'(1) : bn;
            band_total_reg  <= in_band ? sum_sat : tot;
        end else if (cmd.load_mul) begin
            band_total_reg  <= '0;
        end
    end

    // closing band capture and restoring divide
    always_ff @(posedge aclk) begin
        if (cmd.take && stat.band_close) begin
            width_reg  <= hi - lo;
            column_reg <= bn[4:0];
            last_reg   <= (bn + BAND_W'(1)) == BAND_W'(NB);
        end
        if (cmd.load_mul) begin
            ok_reg  <= range_ok;
            rem_reg <= WIDE_W'(band_total_reg) * WIDE_W'(NUM_LEVELS);
            dsh_reg <= WIDE_W'(den) << (QW - 1);
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_column_reg <= column_reg;
            m_height_reg <= ok_reg ? 3'(q_capped) : '0;
            m_last_reg   <= last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_column      = m_column_reg;
    assign m_height      = m_height_reg;
    assign m_last_column = m_last_reg;

endmodule

`default_nettype wire

/* design/spectrum_band_bar_levels.sv */
// a bin that does not close a band is absorbed, one bin per cycle
// a bin that closes a band yields its result after a multiply state, then
// QW = clog2(NUM_LEVELS + 1) divide steps (4 at the default), then a push state
// input stalls through those states, the push state waiting while the output register is full
// reset: synchronous active-low aresetn clears counters, band sum and output valid,
// and loads min_level = -1600 and max_level = -96
`default_nettype none

`include "spectrum_band_bar_levels_defines.svh"

module spectrum_band_bar_levels #(
    parameter int NUM_BANDS  = sbbl_pkg::NUM_BANDS_DEF,
    parameter int NUM_LEVELS = sbbl_pkg::NUM_LEVELS_DEF,
    parameter int NUM_BINS   = sbbl_pkg::NUM_BINS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [sbbl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [sbbl_pkg::LEVEL_W-1:0]        cfg_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  signed [sbbl_pkg::LEVEL_W-1:0] s_power_level,
    input  wire                                 s_frame_start,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [4:0]                          m_column,
    output logic [2:0]                          m_height,
    output logic                                m_last_column
);

    sbbl_pkg::sbbl_cmd_t  cmd;
    sbbl_pkg::sbbl_stat_t stat;

    assign cfg_ready = 1'b1;

    sbbl_ctrl #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sbbl_datapath #(
        .NUM_BANDS  (NUM_BANDS),
        .NUM_LEVELS (NUM_LEVELS),
        .NUM_BINS   (NUM_BINS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_power_level (s_power_level),
        .s_frame_start (s_frame_start),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column      (m_column),
        .m_height      (m_height),
        .m_last_column (m_last_column)
    );

    `SBBL_ASSERT_NOW(a_push_into_free, aclk, aresetn, cmd.push, !m_valid || m_ready, "push while output busy")
    `SBBL_ASSERT_NEXT(a_close_stalls, aclk, aresetn, s_valid && s_ready && stat.band_close, !s_ready, "input not stalled after band close")
    `SBBL_ASSERT_NOW(a_height_cap, aclk, aresetn, m_valid, (NUM_LEVELS > 8) || (m_height <= 3'(NUM_LEVELS - 1)), "height above cap")

endmodule

`default_nettype wire
